[sv/ie_srch_pkg.sv]
// ----------------------------------------------------------------------------
// ie_srch_pkg
// Shared types and constants for the IE list search block.
// ----------------------------------------------------------------------------
package ie_srch_pkg;

  // list size limit and the position counter that must hold it
  localparam int MAX_LIST_BYTES = 2048;
  localparam int POS_W          = $clog2(MAX_LIST_BYTES + 1);

  localparam int LEN_W    = 11;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 8;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // search kinds
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NSHORT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NLONG   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID   = 1'd1;

  // decoded header, from the decoder to the parser
  typedef struct packed {
    logic             type_err;
    logic             match;
    logic [LEN_W-1:0] len;
  } hdr_info_t;

endpackage

[sv/ie_srch_hdr_dec.sv]
// ----------------------------------------------------------------------------
// ie_srch_hdr_dec
// Decodes a 16-bit IE header at the layout of the selected search kind.
// ----------------------------------------------------------------------------
module ie_srch_hdr_dec (
  input  logic [15:0]                      hdr,
  input  logic [ie_srch_pkg::KIND_W-1:0]   kind,
  input  logic [ie_srch_pkg::ID_W-1:0]     target_id,
  output ie_srch_pkg::hdr_info_t           info
);
  import ie_srch_pkg::*;

  logic            type_bit;
  logic [ID_W-1:0] id;
  logic            form_ok;

  assign type_bit = hdr[15];

  always_comb begin
    info.type_err = 1'b0;
    form_ok       = 1'b1;
    case (kind)
      KIND_HEADER: begin
        info.type_err = type_bit;
        info.len      = {4'd0, hdr[6:0]};
        id            = hdr[14:7];
      end
      KIND_PAYLOAD: begin
        info.type_err = !type_bit;
        info.len      = hdr[10:0];
        id            = {4'd0, hdr[14:11]};
      end
      default: begin
        // nested: the header itself says short or long form
        if (type_bit) begin
          info.len = hdr[10:0];
          id       = {4'd0, hdr[14:11]};
        end else begin
          info.len = {3'd0, hdr[7:0]};
          id       = {1'b0, hdr[14:8]};
        end
        form_ok = (type_bit == (kind == KIND_NLONG));
      end
    endcase
    info.match = form_ok && (id == target_id);
  end

endmodule

[sv/ieee802154_ie_list_search.sv]
// ----------------------------------------------------------------------------
// ieee802154_ie_list_search
// Byte-stream search of an IEEE 802.15.4 information-element list.
// ----------------------------------------------------------------------------
// Takes one list byte per cycle. Each byte is parsed in the cycle of its
// transfer and any result it causes appears in the output register on the
// next cycle, so the sustained rate is one byte per clock; in_ready drops only
// while a result sits in the output register and out_ready is low. A list
// gives at most one result: found with content offset and length, invalid, or
// not found; bytes after the result are dropped up to the last-byte flag.
// Configuration writes are taken every cycle and apply from the next header.
// ----------------------------------------------------------------------------
module ieee802154_ie_list_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ie_srch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ie_srch_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ie_srch_pkg::STAT_W-1:0]      out_search_status,
  output logic [ie_srch_pkg::LEN_W-1:0]       out_content_offset,
  output logic [ie_srch_pkg::LEN_W-1:0]       out_content_length
);
  import ie_srch_pkg::*;

  localparam logic [2:0] PH_HDR_LO  = 3'd0;
  localparam logic [2:0] PH_HDR_HI  = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_CONTENT = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  logic [KIND_W-1:0] search_kind_r;
  logic [ID_W-1:0]   target_id_r;

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       hdr_lo_r, hdr_lo_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] moff_r, moff_nxt;
  logic [LEN_W-1:0] mlen_r, mlen_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [LEN_W-1:0]  out_off_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              in_xfer;
  logic              emit;
  logic [STAT_W-1:0] emit_stat;
  logic [LEN_W-1:0]  emit_off;
  logic [LEN_W-1:0]  emit_len;
  logic [POS_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  left_dec;
  hdr_info_t         hinfo;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign pos_inc   = pos_r + POS_W'(1);
  assign left_dec  = left_r - LEN_W'(1);

  ie_srch_hdr_dec u_hdr_dec (
    .hdr       ({in_data_byte, hdr_lo_r}),
    .kind      (search_kind_r),
    .target_id (target_id_r),
    .info      (hinfo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_kind_r <= KIND_HEADER;
      target_id_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEARCH_KIND: search_kind_r <= cfg_wdata[KIND_W-1:0];
        REG_TARGET_ID:   target_id_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    hdr_lo_nxt = hdr_lo_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    moff_nxt   = moff_r;
    mlen_nxt   = mlen_r;
    emit       = 1'b0;
    emit_stat  = ST_NOT_FOUND;

    if (phase_r == PH_DONE) begin
      // drop bytes until the end of the list
    end else if (pos_r >= POS_W'(MAX_LIST_BYTES)) begin
      emit      = 1'b1;
      emit_stat = ST_INVALID;
    end else begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_HDR_LO: begin
          hdr_lo_nxt = in_data_byte;
          phase_nxt  = PH_HDR_HI;
          if (in_last_byte) begin
            emit      = 1'b1;
            emit_stat = ST_INVALID;
          end
        end
        PH_HDR_HI: begin
          if (hinfo.type_err) begin
            emit      = 1'b1;
            emit_stat = ST_INVALID;
          end else if (hinfo.match) begin
            moff_nxt = LEN_W'(pos_inc);
            mlen_nxt = hinfo.len;
            if (hinfo.len == '0) begin
              emit      = 1'b1;
              emit_stat = ST_FOUND;
            end else begin
              left_nxt  = hinfo.len;
              phase_nxt = PH_CONTENT;
              if (in_last_byte) begin
                emit      = 1'b1;
                emit_stat = ST_INVALID;
              end
            end
          end else begin
            if (hinfo.len == '0) begin
              phase_nxt = PH_HDR_LO;
            end else begin
              left_nxt  = hinfo.len;
              phase_nxt = PH_SKIP;
            end
            if (in_last_byte) begin
              emit      = 1'b1;
              emit_stat = ST_NOT_FOUND;
            end
          end
        end
        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_HDR_LO;
          end
          if (in_last_byte) begin
            emit      = 1'b1;
            emit_stat = ST_NOT_FOUND;
          end
        end
        PH_CONTENT: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            emit      = 1'b1;
            emit_stat = ST_FOUND;
          end else if (in_last_byte) begin
            emit      = 1'b1;
            emit_stat = ST_INVALID;
          end
        end
        default: begin
          phase_nxt = PH_HDR_LO;
        end
      endcase
    end

    // result fields come from the match registers before any restart
    emit_off = (emit_stat == ST_FOUND) ? moff_nxt : '0;
    emit_len = (emit_stat == ST_FOUND) ? mlen_nxt : '0;

    if (emit) begin
      phase_nxt = PH_DONE;
    end
    if ((emit || phase_r == PH_DONE || phase_r > PH_DONE) &&
        (in_last_byte || phase_r > PH_DONE)) begin
      phase_nxt  = PH_HDR_LO;
      hdr_lo_nxt = '0;
      left_nxt   = '0;
      pos_nxt    = '0;
      moff_nxt   = '0;
      mlen_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_LO;
      hdr_lo_r <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      moff_r   <= '0;
      mlen_r   <= '0;
    end else if (in_xfer) begin
      phase_r  <= phase_nxt;
      hdr_lo_r <= hdr_lo_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      moff_r   <= moff_nxt;
      mlen_r   <= mlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_stat_r <= emit_stat;
      out_off_r  <= emit_off;
      out_len_r  <= emit_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_search_status  = out_stat_r;
  assign out_content_offset = out_off_r;
  assign out_content_length = out_len_r;

endmodule

[sv/ie_srch_chk.sv]
// ----------------------------------------------------------------------------
// ie_srch_chk
// Port-level checks for the IE list search block.
// ----------------------------------------------------------------------------
module ie_srch_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ie_srch_pkg::STAT_W-1:0]      out_search_status,
  input logic [ie_srch_pkg::LEN_W-1:0]       out_content_offset,
  input logic [ie_srch_pkg::LEN_W-1:0]       out_content_length
);
  import ie_srch_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_search_status) &&
      $stable(out_content_offset) && $stable(out_content_length))
    else $error("result changed while stalled");

  // only a found result carries offset and length
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_search_status != ST_FOUND |->
      out_content_offset == '0 && out_content_length == '0)
    else $error("non-found result with nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_search_status == ST_FOUND ||
      out_search_status == ST_INVALID || out_search_status == ST_NOT_FOUND)
    else $error("unknown status code");

  // every new result follows an input transfer
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

endmodule

bind ieee802154_ie_list_search ie_srch_chk u_ie_srch_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_search_status  (out_search_status),
  .out_content_offset (out_content_offset),
  .out_content_length (out_content_length)
);
